/* rtl/core/swerve_inverse_kinematics_top_assert.svh */
// Assertion macros for the swerve inverse kinematics top level.
// Depends on nothing; included by the top level only.
`ifndef SWERVE_INVERSE_KINEMATICS_TOP_ASSERT_SVH
`define SWERVE_INVERSE_KINEMATICS_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SIK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SIK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/core/sik_pkg.sv */
// Package for swerve inverse kinematics: widths, constants, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sik_pkg;
  localparam int unsigned ModuleCount = 3;
  localparam int unsigned CordicSteps = 24;
  // Q8 velocities after module term fit in 48 bits; CORDIC grows ~1.65x.
  localparam int unsigned VW = 48;
  localparam int unsigned AW = 33;
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;
  localparam logic [23:0] RpmQ16 = 24'd10013163;
  localparam logic [23:0] RpmMax = 24'd8388607;

  typedef enum logic [2:0] {
    REG_PY0 = 3'd0, REG_PX0 = 3'd1, REG_PY1 = 3'd2, REG_PX1 = 3'd3,
    REG_PY2 = 3'd4, REG_PX2 = 3'd5, REG_RAD = 3'd6, REG_NONE = 3'd7
  } reg_idx_e;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/core/sik_cordic.sv */
// Pipelined CORDIC, one micro-rotation per stage, rotation or vectoring.
// Depends on sik_pkg. Stall freezes every stage.
`timescale 1ns / 1ps
`default_nettype none
module sik_cordic #(
  parameter int unsigned W = 48,
  parameter bit VECTOR = 1'b0,
  parameter int unsigned TW = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [W-1:0]  x_i,
  input  wire logic signed [W-1:0]  y_i,
  input  wire logic signed [32:0]   z_i,
  input  wire logic [TW-1:0]        tag_i,
  output logic                      valid_o,
  output logic signed [W-1:0]       x_o,
  output logic signed [W-1:0]       y_o,
  output logic signed [32:0]        z_o,
  output logic [TW-1:0]             tag_o
);
  import sik_pkg::*;
  localparam int unsigned N = CordicSteps;
  logic                valid_q [N+1];
  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [32:0]  z_q [N+1];
  logic [TW-1:0]       tag_q [N+1];

  always_comb begin
    valid_q[0] = valid_i;
    x_q[0] = x_i;
    y_q[0] = y_i;
    z_q[0] = z_i;
    tag_q[0] = tag_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic signed [32:0] at;
    logic dir;
    assign at = signed'({1'b0, atan_lut(5'(i))});
    assign dir = VECTOR ? !y_q[i][W-1] : !z_q[i][32];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i+1] <= tag_q[i];
        if (VECTOR ? dir : !dir) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        end
        if (dir) begin
          z_q[i+1] <= VECTOR ? z_q[i] + at : z_q[i] - at;
        end else begin
          z_q[i+1] <= VECTOR ? z_q[i] - at : z_q[i] + at;
        end
      end
    end
  end

  assign valid_o = valid_q[N];
  assign x_o = x_q[N];
  assign y_o = y_q[N];
  assign z_o = z_q[N];
  assign tag_o = tag_q[N];
endmodule
`default_nettype wire

/* rtl/core/sik_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sik_pkg. Unsigned; divisor nonzero.
`timescale 1ns / 1ps
`default_nettype none
module sik_divider #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 34,
  parameter int unsigned TW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [TW-1:0] tag_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [TW-1:0]      tag_o
);
  import sik_pkg::*;
  logic          valid_q [NW+1];
  logic [NW-1:0] n_q [NW+1];
  logic [DW:0]   r_q [NW+1];
  logic [DW-1:0] d_q [NW+1];
  logic [TW-1:0] tag_q [NW+1];

  always_comb begin
    valid_q[0] = valid_i;
    n_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    tag_q[0] = tag_i;
  end

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {r_q[i], n_q[i][NW-1]};
    assign df = sh - {2'b00, d_q[i]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[i+1] <= d_q[i];
        tag_q[i+1] <= tag_q[i];
        if (!df[DW+1]) begin
          r_q[i+1] <= df[DW:0];
          n_q[i+1] <= {n_q[i][NW-2:0], 1'b1};
        end else begin
          r_q[i+1] <= sh[DW:0];
          n_q[i+1] <= {n_q[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[NW];
  assign quo_o = n_q[NW];
  assign tag_o = tag_q[NW];
endmodule
`default_nettype wire

/* rtl/core/swerve_inverse_kinematics_top.sv */
// Swerve inverse kinematics: each accepted command passes through rotation
// CORDIC, module term, vectoring CORDIC and 64-stage divider to the output.
// Throughput: one module result per cycle while out_stall is not held; the
// serializer issues the three modules of a command in turn, one per result.
// Async active-low reset clears valid bits, serializer and config registers.
`timescale 1ns / 1ps
`default_nettype none
module swerve_inverse_kinematics_top #(
  parameter int unsigned MODULE_COUNT = sik_pkg::ModuleCount
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] vel_x_i,
  input  wire logic signed [15:0] vel_y_i,
  input  wire logic signed [15:0] yaw_rate_i,
  input  wire logic               field_oriented_i,
  input  wire logic signed [15:0] heading_i,
  input  wire logic signed [15:0] steer_now_module0_i,
  input  wire logic signed [15:0] steer_now_module1_i,
  input  wire logic signed [15:0] steer_now_module2_i,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              module_index_o,
  output logic signed [23:0]      wheel_rpm_o,
  output logic signed [15:0]      steer_target_o,
  output logic                    last_module_o,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import sik_pkg::*;
  localparam int unsigned MW = $clog2(MODULE_COUNT);

  // ---------------- configuration registers ----------------
  logic signed [15:0] pos_y_q [MODULE_COUNT];
  logic signed [15:0] pos_x_q [MODULE_COUNT];
  logic [9:0] radius_q;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < MODULE_COUNT; m++) begin
        pos_y_q[m] <= '0;
        pos_x_q[m] <= '0;
      end
      radius_q <= 10'd30;
    end else if (cfg_valid) begin
      if (cfg_index == REG_RAD) begin
        radius_q <= cfg_data[9:0];
      end else if (cfg_index < REG_RAD) begin
        if (cfg_index[0]) pos_x_q[cfg_index[2:1]] <= signed'(cfg_data);
        else pos_y_q[cfg_index[2:1]] <= signed'(cfg_data);
      end
    end
  end

  // Whole pipeline advances when the output stage can move.
  logic en;
  logic outv_q;
  assign en = !outv_q || !out_stall;
  // Front half (input through gain stage) also waits on a busy serializer.
  logic en_f;
  logic bv_q;

  // ---------------- stage A: input register + pre-rotation ----------------
  logic          hold_q;
  logic [MW-1:0] mcnt_q;
  logic signed [15:0] cw_q;
  logic signed [15:0] now_q [MODULE_COUNT];
  assign in_stall = !en_f;
  wire in_acc = in_valid && !in_stall;

  // Rotation pre-step: 2^32 angle, fold into [-1/4,1/4] turn.
  logic signed [32:0] z0;
  logic               flip;
  logic signed [VW-1:0] rx0, ry0;
  always_comb begin
    z0 = signed'({heading_i[15], heading_i, 16'd0});
    flip = 1'b0;
    if (z0 > 33'sh040000000) begin flip = 1'b1; z0 = z0 - 33'sh080000000; end
    else if (z0 < -33'sh040000000) begin flip = 1'b1; z0 = z0 + 33'sh080000000; end
    rx0 = VW'(vel_x_i) <<< 8;
    ry0 = VW'(vel_y_i) <<< 8;
    if (flip) begin rx0 = -rx0; ry0 = -ry0; end
  end

  // Tag carries the raw command alongside the rotation CORDIC.
  localparam int unsigned TA = 1 + 16 + 16 * MODULE_COUNT + VW * 2;
  logic [TA-1:0] tag_a, tag_ra;
  logic          rv;
  logic signed [VW-1:0] rx, ry;
  logic signed [32:0] rz;
  always_comb begin
    tag_a = {field_oriented_i, yaw_rate_i, steer_now_module2_i, steer_now_module1_i,
             steer_now_module0_i, VW'(vel_x_i) <<< 8, VW'(vel_y_i) <<< 8};
  end
  sik_cordic #(.W(VW), .VECTOR(1'b0), .TW(TA)) u_rot (
    .clk_i, .rst_ni, .en_i(en_f), .valid_i(in_acc),
    .x_i(rx0), .y_i(ry0), .z_i(z0), .tag_i(tag_a),
    .valid_o(rv), .x_o(rx), .y_o(ry), .z_o(rz), .tag_o(tag_ra)
  );

  // ---------------- stage B: gain multiply (registered) ----------------
  // Rotated Q8 components stay below 2^25, so a 32x32 product suffices.
  logic signed [63:0] gx_q, gy_q;
  logic [TA-1:0] tag_b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bv_q <= 1'b0;
    else if (en_f) bv_q <= rv;
  end
  always_ff @(posedge clk_i) begin
    if (en_f) begin
      gx_q <= 64'(signed'(rx[31:0])) * 64'(GainQ30);
      gy_q <= 64'(signed'(ry[31:0])) * 64'(GainQ30);
      tag_b_q <= tag_ra;
    end
  end

  // ---------------- stage C: command latch, module serializer ----------------
  // A waiting command loads on the cycle the last module of the previous one
  // issues, so commands follow each other with no gap.
  logic issue_last, ld;
  assign issue_last = hold_q && (mcnt_q == MW'(MODULE_COUNT - 1));
  assign en_f = en && (!bv_q || !hold_q || issue_last);
  assign ld = en_f && bv_q;
  logic signed [VW-1:0] vx_c, vy_c;
  logic fo_c;
  assign fo_c = tag_b_q[TA-1];
  assign vx_c = fo_c ? VW'(gx_q >>> 30) : tag_b_q[2*VW-1:VW];
  assign vy_c = fo_c ? VW'(gy_q >>> 30) : tag_b_q[VW-1:0];
  logic signed [VW-1:0] vx_q, vy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      mcnt_q <= '0;
    end else if (en) begin
      if (ld) begin
        hold_q <= 1'b1;
        mcnt_q <= '0;
      end else if (hold_q) begin
        if (mcnt_q == MW'(MODULE_COUNT - 1)) begin
          hold_q <= 1'b0;
          mcnt_q <= '0;
        end else begin
          mcnt_q <= mcnt_q + 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (ld) begin
      vx_q <= vx_c;
      vy_q <= vy_c;
      cw_q <= tag_b_q[TA-2 -: 16];
      for (int m = 0; m < MODULE_COUNT; m++)
        now_q[m] <= tag_b_q[2*VW + 16*m +: 16];
    end
  end

  // ---------------- stage D: w*pos products ----------------
  logic dv_q;
  logic [MW-1:0] dm_q;
  logic signed [31:0] py_q, px_q;
  logic signed [VW-1:0] dvx_q, dvy_q;
  logic signed [15:0] dnow_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= 1'b0;
    else if (en) dv_q <= hold_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q <= mcnt_q;
      py_q <= 32'(cw_q) * 32'(pos_y_q[mcnt_q]);
      px_q <= 32'(cw_q) * 32'(pos_x_q[mcnt_q]);
      dvx_q <= vx_q;
      dvy_q <= vy_q;
      dnow_q <= now_q[mcnt_q];
    end
  end

  // ---------------- stage E: *256/1000 by reciprocal, truncating ----------------
  // p*256/1000 = p*32/125; |p| <= 2^30, and floor(|p|*K >> 37) with
  // K = ceil(2^42/125) is exact over that range.
  localparam int unsigned DS = 37;
  localparam logic [35:0] RecK = 36'd35184372089;
  logic ev_q;
  logic [MW-1:0] em_q;
  logic [65:0] qy_q, qx_q;
  logic sy_q, sx_q;
  logic signed [VW-1:0] evx_q, evy_q;
  logic signed [15:0] enow_q;
  logic [30:0] ay, ax;
  assign ay = py_q[31] ? 31'(-py_q) : py_q[30:0];
  assign ax = px_q[31] ? 31'(-px_q) : px_q[30:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ev_q <= 1'b0;
    else if (en) ev_q <= dv_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      em_q <= dm_q;
      qy_q <= 66'(ay) * 66'(RecK);
      qx_q <= 66'(ax) * 66'(RecK);
      sy_q <= py_q[31];
      sx_q <= px_q[31];
      evx_q <= dvx_q;
      evy_q <= dvy_q;
      enow_q <= dnow_q;
    end
  end

  // ---------------- stage F: module velocity ----------------
  logic fv_q;
  logic [MW-1:0] fm_q;
  logic signed [VW-1:0] mvx_q, mvy_q;
  logic signed [15:0] fnow_q;
  logic signed [VW-1:0] ty, tx;
  assign ty = sy_q ? -VW'(qy_q >> DS) : VW'(qy_q >> DS);
  assign tx = sx_q ? -VW'(qx_q >> DS) : VW'(qx_q >> DS);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else if (en) fv_q <= ev_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fm_q <= em_q;
      mvx_q <= evx_q - ty;
      mvy_q <= evy_q + tx;
      fnow_q <= enow_q;
    end
  end

  // ---------------- stage G: vectoring CORDIC ----------------
  logic signed [VW-1:0] vx0, vy0;
  logic signed [32:0] vz0;
  assign vx0 = mvx_q[VW-1] ? -mvx_q : mvx_q;
  assign vy0 = mvx_q[VW-1] ? -mvy_q : mvy_q;
  assign vz0 = mvx_q[VW-1] ? 33'sh080000000 : 33'sd0;
  localparam int unsigned TG = MW + 1 + 16;
  logic [TG-1:0] tag_g, tag_gv;
  assign tag_g = {fm_q, (mvx_q == '0) && (mvy_q == '0), fnow_q};
  logic gv;
  logic signed [VW-1:0] gxv, gyv;
  logic signed [32:0] gz;
  sik_cordic #(.W(VW), .VECTOR(1'b1), .TW(TG)) u_vec (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv_q),
    .x_i(vx0), .y_i(vy0), .z_i(vz0), .tag_i(tag_g),
    .valid_o(gv), .x_o(gxv), .y_o(gyv), .z_o(gz), .tag_o(tag_gv)
  );

  // ---------------- stage H: magnitude gain ----------------
  // Vectoring x ends nonnegative and below 2^31.
  logic hv_q;
  logic signed [63:0] hm_q;
  logic [15:0] hang_q;
  logic [TG-1:0] tag_h_q;
  logic [31:0] zr;
  assign zr = gz[31:0] + 32'h8000;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hv_q <= 1'b0;
    else if (en) hv_q <= gv;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hm_q <= 64'(signed'(gxv[31:0])) * 64'(GainQ30);
      hang_q <= zr[31:16];
      tag_h_q <= tag_gv;
    end
  end

  // ---------------- stage I: speed numerator ----------------
  logic iv_q;
  logic [63:0] num_q;
  logic [15:0] iang_q;
  logic [TG-1:0] tag_i_q;
  logic signed [VW-1:0] mag;
  logic [39:0] magc;
  assign mag = VW'(hm_q >>> 30);
  assign magc = mag[VW-1] ? '0 : mag[39:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iv_q <= 1'b0;
    else if (en) iv_q <= hv_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= 64'(magc) * 64'(RpmQ16) + ({54'd0, (radius_q == '0) ? 10'd1 : radius_q} << 23);
      iang_q <= hang_q;
      tag_i_q <= tag_h_q;
    end
  end

  // ---------------- stage J: divide by r*2^24 ----------------
  localparam int unsigned TJ = TG + 16;
  logic jv;
  logic [63:0] quo;
  logic [TJ-1:0] tag_j;
  sik_divider #(.NW(64), .DW(34), .TW(TJ)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(iv_q),
    .num_i(num_q), .den_i({(radius_q == '0) ? 10'd1 : radius_q, 24'd0}),
    .tag_i({tag_i_q, iang_q}),
    .valid_o(jv), .quo_o(quo), .tag_o(tag_j)
  );

  // ---------------- stage K: saturate, reverse, output register ----------------
  logic [MW-1:0] km;
  logic kzero;
  logic signed [15:0] know, kang;
  assign {km, kzero, know, kang} = tag_j;
  logic [23:0] spd;
  logic [15:0] st, dd;
  logic rev;
  always_comb begin
    spd = (quo > 64'(RpmMax)) ? RpmMax : quo[23:0];
    st = kang;
    if (kzero) begin
      spd = '0;
      st = know;
    end
    dd = know - st;
    rev = (signed'(dd) > 16'sd16384) || (signed'(dd) < -16'sd16384);
  end
  logic [1:0] om_q;
  logic [23:0] orpm_q;
  logic [15:0] ost_q;
  logic ol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) outv_q <= 1'b0;
    else if (en) outv_q <= jv;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      om_q <= 2'(km);
      orpm_q <= rev ? -spd : spd;
      ost_q <= rev ? st + 16'h8000 : st;
      ol_q <= (km == MW'(MODULE_COUNT - 1));
    end
  end
  assign out_valid = outv_q;
  assign module_index_o = om_q;
  assign wheel_rpm_o = signed'(orpm_q);
  assign steer_target_o = signed'(ost_q);
  assign last_module_o = ol_q;

  `include "swerve_inverse_kinematics_top_assert.svh"
  `SIK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(wheel_rpm_o), "stalled result changed")
  `SIK_ASSERT_IMP(a_idx_range, clk_i, rst_ni, out_valid, module_index_o < 2'(MODULE_COUNT), "bad module index")
  `SIK_ASSERT_IMP(a_last, clk_i, rst_ni, out_valid, last_module_o == (module_index_o == 2'(MODULE_COUNT - 1)), "last flag mismatch")
endmodule
`default_nettype wire
